@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ rtl/core/ftrl_pkg.sv @@
// Package for the FTRL coordinate update: shared constants and types.
`timescale 1ns / 1ps
package ftrl_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned SqW   = 48;
  localparam logic [SqW-1:0] SqMax = {SqW{1'b1}};

  typedef enum logic [1:0] {
    REG_ALPHA = 2'd0,
    REG_BETA  = 2'd1,
    REG_L1    = 2'd2,
    REG_L2    = 2'd3
  } reg_idx_t;

  // Request to and response from the bit-serial divide and root unit.
  typedef struct packed {
    logic        start;
    logic        is_root;
    logic [63:0] num;
    logic [63:0] den;
  } ser_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } ser_rsp_t;
endpackage

@@ rtl/core/ftrl_proximal_coordinate_update.sv @@
// Top level of the FTRL-proximal per-coordinate optimiser.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  request  | valid / ready      | coord_index, gradient
//  result   | out_valid/out_ready| coord_echo, new_weight, weight_is_zero
//  config   | cfg_we             | cfg_index, cfg_data
//
// Between acceptance of one request and the next possible acceptance the block
// reduces the index in 12 steps, runs two roots and three divisions in the shared
// bit-serial unit, and takes seven single sequencer steps. A weight forced to zero
// skips both weight divisions; a zero denominator skips the last one. After reset a
// clearing pass writes zero to every coordinate, during which no request is taken.
// One request is in work at a time; a stalled result holds the block in its output
// state.
`timescale 1ns / 1ps
module ftrl_proximal_coordinate_update #(
  parameter int unsigned COORDS = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      valid,
  output logic                      ready,
  input  logic [11:0]               coord_index,
  input  logic signed [31:0]        gradient,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [11:0]               coord_echo,
  output logic signed [31:0]        new_weight,
  output logic                      weight_is_zero,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data
);
  import ftrl_pkg::*;

  localparam int unsigned AW = (COORDS > 1) ? $clog2(COORDS) : 1;
  localparam logic [31:0] CoordsW = 32'(COORDS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REDUCE, S_READ, S_LATCH, S_ROOT_OLD, S_ROOT_NEW, S_SIGMA,
    S_MUL, S_ZUPD, S_DEN, S_WDIV, S_WRITE, S_OUT
  } state_t;

  state_t state;
  logic [31:0] alpha, beta, lam1, lam2;
  logic [AW-1:0] addr, clr_addr;
  logic [11:0] idx_reg;
  logic [3:0]  red_k;
  logic [31:0] red_sub;
  logic signed [31:0] g_reg;
  logic signed [31:0] z_old, w_old, z_new;
  logic [SqW-1:0] n_old, n_new;
  logic [31:0] r_old, r_new;
  logic [31:0] sigma;
  logic [63:0] prod;
  logic [31:0] z_rd, w_rd;
  logic [SqW-1:0] n_rd;
  logic ram_we;
  logic [31:0] z_wd, w_wd;
  logic [SqW-1:0] n_wd;
  logic [64:0] den;
  logic [31:0] w_out;
  logic        zflag;
  logic        ser_wait;
  logic        start_next;
  ser_req_t    sreq;
  ser_rsp_t    srsp;

  logic [31:0] gmag;
  logic [63:0] gsq_full;
  logic [SqW-1:0] gsq;
  logic [SqW:0] nsum;
  logic [31:0] alpha_eff;
  logic [31:0] wmag;
  logic [39:0] tmag;
  logic signed [41:0] zsum;
  logic [31:0] zmag;

  assign gmag      = g_reg[31] ? 32'(-g_reg) : 32'(g_reg);
  assign gsq_full  = gmag * gmag;
  assign gsq       = gsq_full[63:16];
  assign nsum      = {1'b0, n_old} + {1'b0, gsq};
  assign alpha_eff = (alpha == 32'd0) ? 32'd1 : alpha;
  assign wmag      = w_old[31] ? 32'(-w_old) : 32'(w_old);
  assign tmag      = prod[63:24];
  assign zmag      = z_new[31] ? 32'(-z_new) : 32'(z_new);

  // The index is reduced modulo COORDS by compare and subtract of COORDS << k.
  assign red_sub   = CoordsW << red_k;

  always_comb begin
    zsum = 42'(z_old) + 42'(g_reg) - (w_old[31] ? -42'(tmag) : 42'(tmag));
  end

  assign start_next = !ser_wait && ((state == S_ROOT_OLD) || (state == S_ROOT_NEW) ||
                                    (state == S_SIGMA) ||
                                    ((state == S_DEN) && (zmag > lam1)) ||
                                    ((state == S_WDIV) && (den != '0)));

  assign ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign coord_echo = idx_reg;
  assign new_weight = w_out;
  assign weight_is_zero = zflag;

  assign ram_we = (state == S_CLEAR) || (state == S_WRITE);
  assign addr   = (state == S_CLEAR) ? clr_addr : AW'(idx_reg);
  assign z_wd   = (state == S_CLEAR) ? '0 : z_new;
  assign n_wd   = (state == S_CLEAR) ? '0 : n_new;
  assign w_wd   = (state == S_CLEAR) ? '0 : w_out;

  ftrl_ram #(.Width(32), .Depth(COORDS)) u_z (
    .clk(clk), .we(ram_we), .addr(addr), .wdata(z_wd), .rdata(z_rd));
  ftrl_ram #(.Width(SqW), .Depth(COORDS)) u_n (
    .clk(clk), .we(ram_we), .addr(addr), .wdata(n_wd), .rdata(n_rd));
  ftrl_ram #(.Width(32), .Depth(COORDS)) u_w (
    .clk(clk), .we(ram_we), .addr(addr), .wdata(w_wd), .rdata(w_rd));

  ftrl_serial u_ser (.clk(clk), .rst(rst), .req(sreq), .rsp(srsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= 32'h0100_0000;
      beta  <= 32'h0100_0000;
      lam1  <= 32'd0;
      lam2  <= 32'h0100_0000;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ALPHA: alpha <= cfg_data;
        REG_BETA:  beta  <= cfg_data;
        REG_L1:    lam1  <= cfg_data;
        REG_L2:    lam2  <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      ser_wait   <= 1'b0;
      sreq.start <= 1'b0;
    end else begin
      sreq.start <= start_next;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(COORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (valid) begin
            idx_reg <= coord_index;
            red_k   <= 4'd11;
            g_reg   <= gradient;
            state   <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if ({20'd0, idx_reg} >= red_sub) idx_reg <= idx_reg - red_sub[11:0];
          if (red_k == 4'd0) state <= S_READ;
          else red_k <= red_k - 4'd1;
        end
        S_READ: state <= S_LATCH;
        S_LATCH: begin
          z_old <= z_rd;
          n_old <= n_rd;
          w_old <= w_rd;
          state <= S_ROOT_OLD;
        end
        S_ROOT_OLD: begin
          n_new <= nsum[SqW] ? SqMax : nsum[SqW-1:0];
          if (!ser_wait) begin
            sreq.is_root <= 1'b1;
            sreq.num     <= {n_old, 16'd0};
            sreq.den     <= '0;
            ser_wait     <= 1'b1;
          end else if (srsp.done) begin
            r_old    <= srsp.res[31:0];
            ser_wait <= 1'b0;
            state    <= S_ROOT_NEW;
          end
        end
        S_ROOT_NEW: begin
          if (!ser_wait) begin
            sreq.is_root <= 1'b1;
            sreq.num     <= {n_new, 16'd0};
            ser_wait     <= 1'b1;
          end else if (srsp.done) begin
            r_new    <= srsp.res[31:0];
            ser_wait <= 1'b0;
            state    <= S_SIGMA;
          end
        end
        S_SIGMA: begin
          if (!ser_wait) begin
            sreq.is_root <= 1'b0;
            sreq.num     <= (r_new >= r_old) ? {8'd0, r_new - r_old, 24'd0} : '0;
            sreq.den     <= {32'd0, alpha_eff};
            ser_wait     <= 1'b1;
          end else if (srsp.done) begin
            sigma    <= (srsp.res[63:32] != 32'd0) ? 32'hFFFF_FFFF : srsp.res[31:0];
            ser_wait <= 1'b0;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= sigma * wmag;
          state <= S_ZUPD;
        end
        S_ZUPD: begin
          if (zsum > 42'sd2147483647) z_new <= 32'h7FFF_FFFF;
          else if (zsum < -42'sd2147483648) z_new <= 32'h8000_0000;
          else z_new <= zsum[31:0];
          state <= S_DEN;
        end
        S_DEN: begin
          if (zmag <= lam1) begin
            w_out <= '0;
            zflag <= 1'b1;
            state <= S_WRITE;
          end else if (!ser_wait) begin
            zflag        <= 1'b0;
            sreq.is_root <= 1'b0;
            sreq.num     <= {7'd0, {1'b0, beta} + {1'b0, r_new}, 24'd0};
            sreq.den     <= {32'd0, alpha_eff};
            ser_wait     <= 1'b1;
          end else if (srsp.done) begin
            den      <= {1'b0, srsp.res} + {33'd0, lam2};
            ser_wait <= 1'b0;
            state    <= S_WDIV;
          end
        end
        S_WDIV: begin
          if (den == '0) begin
            w_out <= z_new[31] ? 32'h7FFF_FFFF : 32'h8000_0000;
            state <= S_WRITE;
          end else if (!ser_wait) begin
            sreq.is_root <= 1'b0;
            sreq.num     <= {8'd0, zmag - lam1, 24'd0};
            sreq.den     <= den[63:0];
            ser_wait     <= 1'b1;
          end else if (srsp.done) begin
            ser_wait <= 1'b0;
            if (z_new[31]) begin
              w_out <= (srsp.res[63:31] != 33'd0) ? 32'h7FFF_FFFF : srsp.res[31:0];
            end else begin
              w_out <= (srsp.res[63:31] != 33'd0) ? 32'h8000_0000 : 32'(-srsp.res[31:0]);
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(hs_excl, clk, rst, !(ready && out_valid))
  `ASSERT_CLK(zero_flag_w, clk, rst, (out_valid && weight_is_zero) |-> new_weight == 32'd0)
  `ASSERT_CLK(out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid && $stable(new_weight))
  `ASSERT_CLK(idle_serial, clk, rst, ready |-> !ser_wait)
endmodule

@@ rtl/core/ftrl_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module ftrl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/core/ftrl_serial.sv @@
// Shared bit-serial unit: restoring division or integer square root, one bit a cycle.
`timescale 1ns / 1ps
module ftrl_serial (
  input  logic             clk,
  input  logic             rst,
  input  ftrl_pkg::ser_req_t req,
  output ftrl_pkg::ser_rsp_t rsp
);
  import ftrl_pkg::*;

  logic        busy;
  logic        done_q;
  logic        root_mode;
  logic [6:0]  cnt;
  logic [63:0] nsr;
  logic [63:0] den;
  logic [64:0] rem;
  logic [63:0] quo;
  logic [64:0] trial;
  logic [64:0] rem_sh;

  // Root step takes two numerator bits; the trial subtrahend is 4q+1.
  always_comb begin
    if (root_mode) begin
      rem_sh = {rem[62:0], nsr[63:62]};
      trial  = {quo[62:0], 2'b01};
    end else begin
      rem_sh = {rem[63:0], nsr[63]};
      trial  = {1'b0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy      <= 1'b1;
        root_mode <= req.is_root;
        cnt       <= req.is_root ? 7'd32 : 7'd64;
        nsr       <= req.num;
        den       <= req.den;
        rem       <= '0;
        quo       <= '0;
      end else if (busy) begin
        nsr <= root_mode ? {nsr[61:0], 2'b00} : {nsr[62:0], 1'b0};
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_q, res: quo};

  `include "assert_macros.svh"
  `ASSERT_CLK(no_start_busy, clk, rst, busy |-> !req.start)
  `ASSERT_CLK(done_ends, clk, rst, rsp.done |-> !busy)
  `ASSERT_CLK(cnt_live, clk, rst, busy |-> cnt != 7'd0)
endmodule

@@ sim/tb_top.sv @@
// Testbench for the FTRL-proximal coordinate update: driven requests, predicted weights.
`timescale 1ns / 1ps
module tb_top;
  import ftrl_pkg::*;

  localparam int unsigned NCOORD = 4096;
  localparam logic [47:0] NMAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [11:0]        coord;
    logic signed [31:0] weight;
    logic               zero;
  } weight_result_t;

  class weight_scoreboard;
    logic [31:0] alpha, beta, lam1, lam2;
    logic signed [31:0] z_acc [NCOORD];
    logic [47:0] n_sum [NCOORD];
    logic signed [31:0] w_mem [NCOORD];
    weight_result_t pending [$];
    int errors;

    function new();
      alpha = 32'h0100_0000;
      beta = 32'h0100_0000;
      lam1 = 0;
      lam2 = 32'h0100_0000;
      errors = 0;
      foreach (z_acc[i]) begin
        z_acc[i] = 0;
        n_sum[i] = 0;
        w_mem[i] = 0;
      end
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_ALPHA: alpha = val;
        REG_BETA:  beta = val;
        REG_L1:    lam1 = val;
        default:   lam2 = val;
      endcase
    endfunction

    function logic [63:0] int_root(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_request(logic [11:0] coord, logic signed [31:0] grad);
      logic [63:0] a, gmag, gsq, n_old, n_new, r_old, r_new, d, sigma, wmag, tmag, zmag;
      logic [63:0] num, den, qmag;
      longint g, w, term, z, wout;
      weight_result_t r;
      a = (alpha == 0) ? 64'd1 : {32'd0, alpha};
      g = grad;
      gmag = (g < 0) ? -g : g;
      n_old = {16'd0, n_sum[coord]};
      gsq = (gmag * gmag) >> 16;
      n_new = (gsq > {16'd0, NMAX} - n_old) ? {16'd0, NMAX} : n_old + gsq;
      r_old = int_root(n_old << 16);
      r_new = int_root(n_new << 16);
      d = (r_new >= r_old) ? r_new - r_old : 0;
      sigma = (d << 24) / a;
      if (sigma > 64'hFFFF_FFFF) sigma = 64'hFFFF_FFFF;
      w = w_mem[coord];
      wmag = (w < 0) ? -w : w;
      tmag = (sigma * wmag) >> 24;
      term = (w < 0) ? -longint'(tmag) : longint'(tmag);
      z = clamp32(longint'(z_acc[coord]) + g - term);
      z_acc[coord] = z[31:0];
      n_sum[coord] = n_new[47:0];
      zmag = (z < 0) ? -z : z;
      r.coord = coord;
      r.zero = 0;
      if (zmag <= {32'd0, lam1}) begin
        wout = 0;
        r.zero = 1;
      end else begin
        num = zmag - lam1;
        den = ((({32'd0, beta} + r_new) << 24) / a) + lam2;
        qmag = (den == 0) ? (64'd1 << 40) : (num << 24) / den;
        if (qmag > (64'd1 << 40)) qmag = 64'd1 << 40;
        wout = clamp32((z < 0) ? longint'(qmag) : -longint'(qmag));
      end
      w_mem[coord] = wout[31:0];
      r.weight = wout[31:0];
      pending.push_back(r);
    endfunction

    function void check_result(weight_result_t got);
      weight_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result coord=%0d weight=%0d", $time, got.coord, got.weight);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.coord !== exp_r.coord) begin
        $display("%0t: coord_echo expected %0d got %0d", $time, exp_r.coord, got.coord);
        errors++;
      end
      if (got.weight !== exp_r.weight) begin
        $display("%0t: new_weight expected %0d got %0d", $time, exp_r.weight, got.weight);
        errors++;
      end
      if (got.zero !== exp_r.zero) begin
        $display("%0t: weight_is_zero expected %0b got %0b", $time, exp_r.zero, got.zero);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic valid = 0, out_ready = 0, cfg_we = 0;
  logic [11:0] coord_index = 0;
  logic signed [31:0] gradient = 0;
  logic [1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic ready, out_valid, weight_is_zero;
  logic [11:0] coord_echo;
  logic signed [31:0] new_weight;
  int unsigned out_gap = 0;
  int unsigned out_draw;

  weight_scoreboard sb = new();

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  ftrl_proximal_coordinate_update dut (.*);

  // Valid stays high into the next request when no idle cycles are drawn.
  task automatic send_request(logic [11:0] c, logic signed [31:0] g);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      valid <= 0;
      repeat (gap) @(posedge clk);
    end
    valid <= 1;
    coord_index <= c;
    gradient <= g;
    do @(posedge clk); while (!ready);
    sb.note_request(c, g);
  endtask

  // The caller lowers cfg_we after the last write of a group.
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic wait_idle();
    valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly a small hot set of coordinates so that z, n and weight build up history.
  function automatic logic [11:0] pick_coord();
    if ($urandom_range(0, 3) != 0) return 12'($urandom_range(0, 15));
    return 12'($urandom);
  endfunction

  function automatic logic signed [31:0] pick_grad();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
      2: return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
    endcase
  endfunction

  // Result side: each result waits a drawn number of cycles before it is taken.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      out_gap <= 0;
    end else if (out_valid && out_ready) begin
      sb.check_result('{coord_echo, new_weight, weight_is_zero});
      out_draw = $urandom_range(0, 3);
      out_ready <= (out_draw == 0);
      out_gap <= (out_draw == 0) ? 0 : out_draw - 1;
    end else if (out_valid && !out_ready) begin
      if (out_gap == 0) out_ready <= 1;
      else out_gap <= out_gap - 1;
    end
  end

  initial begin
    logic [31:0] cfg_sets [5][4];
    cfg_sets = '{
      '{32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0100_0000},
      '{32'h0, 32'h0, 32'h0, 32'h0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{32'h0000_0001, 32'h0, 32'h0080_0000, 32'h0},
      '{32'h0040_0000, 32'h0200_0000, 32'h0010_0000, 32'h0080_0000}
    };
    repeat (12) @(posedge clk);
    rst <= 0;
    // Directed: field extremes, zero gradient, threshold and all-zero configuration cases.
    send_request(12'd0, 32'sh0100_0000);
    send_request(12'd0, 32'sh8000_0000);
    send_request(12'd4095, 32'sh7FFF_FFFF);
    send_request(12'd4095, 32'sh7FFF_FFFF);
    send_request(12'd1, 32'sd0);
    send_request(12'd2, -32'sd1);
    send_request(12'd2, 32'sd1);
    wait_idle();
    write_reg(REG_L1, 32'h0200_0000);
    cfg_we <= 0;
    send_request(12'd3, 32'sh0100_0000);
    send_request(12'd3, 32'sh0300_0000);
    wait_idle();
    write_reg(REG_ALPHA, 32'h0);
    write_reg(REG_BETA, 32'h0);
    write_reg(REG_L1, 32'h0);
    write_reg(REG_L2, 32'h0);
    cfg_we <= 0;
    send_request(12'd5, 32'sd0);
    send_request(12'd6, 32'sh0000_0100);
    send_request(12'd6, -32'sh0100_0000);
    wait_idle();
    for (int ph = 0; ph < 10; ph++) begin
      for (int r = 0; r < 4; r++) begin
        if (ph < 5) write_reg(reg_idx_t'(r), cfg_sets[ph][r]);
        else write_reg(reg_idx_t'(r), (r == 0) ? 32'($urandom_range(1, 32'h0400_0000))
                                           : 32'($urandom_range(0, 32'h0400_0000)));
      end
      cfg_we <= 0;
      for (int i = 0; i < 195; i++) send_request(pick_coord(), pick_grad());
      wait_idle();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ftrl_pkg.sv
rtl/core/ftrl_ram.sv
rtl/core/ftrl_serial.sv
rtl/core/ftrl_proximal_coordinate_update.sv
sim/tb_top.sv
